// ===== design/vertex_mvp_transform_unit_assert.svh =====
// assertion macros used by the port checker
`ifndef VERTEX_MVP_TRANSFORM_UNIT_ASSERT_SVH
`define VERTEX_MVP_TRANSFORM_UNIT_ASSERT_SVH

// same-cycle implication, idle during reset
`define VMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define VMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/vmt_pkg.sv =====
// shared types and codes of the vertex transform unit
package vmt_pkg;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_VERTEX = 1'b1
  } action_t;

  localparam logic [1:0] MSEL_MODEL  = 2'd0;
  localparam logic [1:0] MSEL_VIEW   = 2'd1;
  localparam logic [1:0] MSEL_PROJ   = 2'd2;
  localparam logic [1:0] MSEL_UNUSED = 2'd3;

  localparam int unsigned COEF_COUNT = 16;

  // coefficient load control travelling with each item
  typedef struct packed {
    logic       load;
    logic [1:0] sel;
    logic [3:0] idx;
  } ld_ctl_t;

endpackage

// ===== design/vmt_matvec.sv =====
// one 4x4 matrix times vector stage: coefficient store, product stage, row sum stage
module vmt_matvec
  import vmt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  parameter logic [1:0] MATRIX_SEL = MSEL_MODEL,
  parameter int CARRY_WIDTH = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ld_ctl_t                             in_ctl,
  input  logic [VALUE_WIDTH-1:0]              in_coef,
  input  logic [3:0][VALUE_WIDTH-1:0]         in_vec,
  input  logic [CARRY_WIDTH-1:0]              in_carry,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ld_ctl_t                             out_ctl,
  output logic [VALUE_WIDTH-1:0]              out_coef,
  output logic [3:0][VALUE_WIDTH-1:0]         out_vec,
  output logic [CARRY_WIDTH-1:0]              out_carry
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = W + 2;
  localparam logic signed [PW-1:0] PONE  = PW'(1);
  localparam logic signed [PW-1:0] PZERO = PW'(0);
  localparam logic signed [PW-1:0] PMAX  = (PONE <<< (W - 1)) - PONE;
  localparam logic signed [PW-1:0] PMIN  = -PMAX - PONE;
  localparam logic signed [PW-1:0] BIAS  = (PONE <<< FRAC_BITS) - PONE;
  localparam logic signed [SW-1:0] SONE  = SW'(1);
  localparam logic signed [SW-1:0] SMAX  = (SONE <<< (W - 1)) - SONE;
  localparam logic signed [SW-1:0] SMIN  = -SMAX - SONE;

  logic [W-1:0] coef_mem [COEF_COUNT];

  logic                       b_valid;
  ld_ctl_t                    b_ctl;
  logic [W-1:0]               b_coef;
  logic signed [PW-1:0]       b_prod [COEF_COUNT];
  logic [CARRY_WIDTH-1:0]     b_carry;

  logic                       c_valid;
  ld_ctl_t                    c_ctl;
  logic [W-1:0]               c_coef;
  logic [3:0][W-1:0]          c_vec;
  logic [CARRY_WIDTH-1:0]     c_carry;

  logic                       en_b;
  logic                       en_c;
  logic signed [PW-1:0]       prod_next [COEF_COUNT];
  logic [3:0][W-1:0]          c_vec_next;

  // product scaled back by the fraction, truncated toward zero, saturated
  function automatic logic signed [W-1:0] scale_term(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + (p[PW-1] ? BIAS : PZERO);
    t = t >>> FRAC_BITS;
    if (t > PMAX) return W'(PMAX);
    if (t < PMIN) return W'(PMIN);
    return W'(t);
  endfunction

  assign en_c     = !c_valid || out_ready;
  assign en_b     = !b_valid || en_c;
  assign in_ready = en_b;

  // a load updates the store while it waits at this stage's input
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < COEF_COUNT; k++) coef_mem[k] <= '0;
    end else if (in_valid && in_ctl.load && in_ctl.sel == MATRIX_SEL) begin
      coef_mem[in_ctl.idx] <= in_coef;
    end
  end

  always_comb begin
    for (int k = 0; k < COEF_COUNT; k++) begin
      prod_next[k] = PW'(signed'(coef_mem[k])) * PW'(signed'(in_vec[k % 4]));
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) acc = acc + SW'(scale_term(b_prod[r * 4 + c]));
      if (acc > SMAX)      c_vec_next[r] = W'(SMAX);
      else if (acc < SMIN) c_vec_next[r] = W'(SMIN);
      else                 c_vec_next[r] = W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_b) b_valid <= in_valid;
      if (en_c) c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_ctl   <= in_ctl;
      b_coef  <= in_coef;
      b_carry <= in_carry;
      for (int k = 0; k < COEF_COUNT; k++) b_prod[k] <= prod_next[k];
    end
    if (en_c) begin
      c_ctl   <= b_ctl;
      c_coef  <= b_coef;
      c_carry <= b_carry;
      c_vec   <= c_vec_next;
    end
  end

  assign out_valid = c_valid;
  assign out_ctl   = c_ctl;
  assign out_coef  = c_coef;
  assign out_vec   = c_vec;
  assign out_carry = c_carry;

endmodule

// ===== design/vmt_divide.sv =====
// pipelined restoring divider: clip x, y, z over clip w, one quotient bit per stage
module vmt_divide
  import vmt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  parameter int CARRY_WIDTH = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0][VALUE_WIDTH-1:0] in_clip,
  input  logic [CARRY_WIDTH-1:0]      in_carry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0][VALUE_WIDTH-1:0] out_ndc,
  output logic                        out_error,
  output logic [CARRY_WIDTH-1:0]      out_carry
);

  localparam int W  = VALUE_WIDTH;
  localparam int DW = VALUE_WIDTH + FRAC_BITS;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // stage 0 holds the prepared operands, stages 1..W one quotient bit each
  logic                   v     [0:W];
  logic [W-1:0]           mw    [0:W];
  logic                   err   [0:W];
  logic [CARRY_WIDTH-1:0] carry [0:W];
  logic [W-1:0]           rem   [0:W][0:2];
  logic [W-1:0]           dq    [0:W][0:2];
  logic                   neg   [0:W][0:2];
  logic                   over  [0:W][0:2];
  logic                   en    [0:W+1];

  logic [W-1:0]           rem_next [1:W][0:2];
  logic [W-1:0]           dq_next  [1:W][0:2];

  logic [W-1:0]           mw0;
  logic [W-1:0]           rem0  [0:2];
  logic [W-1:0]           dq0   [0:2];
  logic                   neg0  [0:2];
  logic                   over0 [0:2];

  logic                   fin_valid;
  logic                   fin_error;
  logic [2:0][W-1:0]      fin_ndc;
  logic [CARRY_WIDTH-1:0] fin_carry;
  logic [2:0][W-1:0]      fin_ndc_next;

  always_comb begin
    logic [W-1:0]  mc;
    logic [DW-1:0] d;
    logic [DW-1:0] hi;
    mw0 = in_clip[3][W-1] ? W'(-in_clip[3]) : in_clip[3];
    for (int i = 0; i < 3; i++) begin
      mc       = in_clip[i][W-1] ? W'(-in_clip[i]) : in_clip[i];
      d        = DW'(mc) << FRAC_BITS;
      hi       = d >> W;
      over0[i] = hi >= DW'(mw0);
      neg0[i]  = in_clip[i][W-1] ^ in_clip[3][W-1];
      rem0[i]  = W'(hi);
      dq0[i]   = W'(d);
    end
  end

  always_comb begin
    logic [W:0] t;
    for (int k = 1; k <= W; k++) begin
      for (int i = 0; i < 3; i++) begin
        t = {rem[k-1][i], dq[k-1][i][W-1]};
        if (t >= {1'b0, mw[k-1]}) begin
          rem_next[k][i] = W'(t - {1'b0, mw[k-1]});
          dq_next[k][i]  = {dq[k-1][i][W-2:0], 1'b1};
        end else begin
          rem_next[k][i] = W'(t);
          dq_next[k][i]  = {dq[k-1][i][W-2:0], 1'b0};
        end
      end
    end
  end

  // sign, overflow and zero divisor applied to the magnitude quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (err[W])               fin_ndc_next[i] = '0;
      else if (over[W][i])      fin_ndc_next[i] = neg[W][i] ? VMIN : VMAX;
      else if (neg[W][i])       fin_ndc_next[i] = dq[W][i][W-1] ? VMIN : W'(-dq[W][i]);
      else                      fin_ndc_next[i] = dq[W][i][W-1] ? VMAX : dq[W][i];
    end
  end

  always_comb begin
    en[W+1] = !fin_valid || out_ready;
    for (int k = W; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= W; k++) v[k] <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= W; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en[W+1]) fin_valid <= v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mw[0]    <= mw0;
      err[0]   <= in_clip[3] == '0;
      carry[0] <= in_carry;
      for (int i = 0; i < 3; i++) begin
        rem[0][i]  <= rem0[i];
        dq[0][i]   <= dq0[i];
        neg[0][i]  <= neg0[i];
        over[0][i] <= over0[i];
      end
    end
    for (int k = 1; k <= W; k++) begin
      if (en[k]) begin
        mw[k]    <= mw[k-1];
        err[k]   <= err[k-1];
        carry[k] <= carry[k-1];
        for (int i = 0; i < 3; i++) begin
          rem[k][i]  <= rem_next[k][i];
          dq[k][i]   <= dq_next[k][i];
          neg[k][i]  <= neg[k-1][i];
          over[k][i] <= over[k-1][i];
        end
      end
    end
    if (en[W+1]) begin
      fin_ndc   <= fin_ndc_next;
      fin_error <= err[W];
      fin_carry <= carry[W];
    end
  end

  assign out_valid = fin_valid;
  assign out_ndc   = fin_ndc;
  assign out_error = fin_error;
  assign out_carry = fin_carry;

endmodule

// ===== design/vertex_mvp_transform_unit.sv =====
// vertex transform unit top level: input register, three matrix stages, divider
// throughput: one item per cycle when out_ready does not hold the pipeline back;
// each matrix stage has a product stage and a row sum stage, the divider takes
// one quotient bit per stage between its operand stage and its output register
// reset: synchronous, clears all valid bits and the model, view and projection
// matrices to zero
module vertex_mvp_transform_unit
  import vmt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [1:0]         matrix_select,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic signed [31:0] world_w,
  output logic signed [31:0] ndc_x,
  output logic signed [31:0] ndc_y,
  output logic signed [31:0] ndc_z,
  output logic signed [31:0] view_depth,
  output logic               divide_error
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = 5 * W;
  localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
  localparam logic signed [63:0] ONE64  = 64'sd1 <<< FRAC_BITS;
  // homogeneous w of the object position: one, saturated to the value range
  localparam logic [W-1:0] POS_W = (ONE64 > VMAX64) ? W'(VMAX64) : W'(ONE64);
  localparam logic [W-1:0] VMAX = W'(VMAX64);
  localparam logic [W-1:0] VMIN = W'(VMIN64);

  // 32-bit port value brought into the internal value range
  function automatic logic [W-1:0] to_value(input logic [31:0] x);
    logic signed [63:0] e;
    e = 64'(signed'(x));
    if (e > VMAX64) return W'(VMAX64);
    if (e < VMIN64) return W'(VMIN64);
    return W'(e);
  endfunction

  // depth is minus view z; the most negative value saturates
  function automatic logic [W-1:0] neg_sat(input logic [W-1:0] v);
    if (v == VMIN) return VMAX;
    return W'(-v);
  endfunction

  // input register
  logic              r0_valid;
  ld_ctl_t           r0_ctl;
  logic [W-1:0]      r0_coef;
  logic [3:0][W-1:0] r0_vec;
  logic              en_r0;

  // stage interconnect
  logic              m_in_ready, m_valid, v_in_ready, v_valid;
  logic              p_in_ready, p_valid, p_ready, d_in_ready, d_valid;
  ld_ctl_t           m_ctl, v_ctl, p_ctl;
  logic [W-1:0]      m_coef, v_coef, p_coef;
  logic [3:0][W-1:0] m_vec, v_vec, p_vec;
  logic [CW-1:0]     m_carry, v_carry, p_carry, d_carry;
  logic [CW-1:0]     v_carry_in, p_carry_in;
  logic [2:0][W-1:0] d_ndc;
  logic              d_error;

  assign en_r0    = !r0_valid || m_in_ready;
  assign in_ready = en_r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (en_r0) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_r0) begin
      r0_ctl.load <= action == ACT_LOAD;
      r0_ctl.sel  <= matrix_select;
      r0_ctl.idx  <= coef_index;
      r0_coef     <= to_value(coef_value);
      r0_vec[0]   <= to_value(pos_x);
      r0_vec[1]   <= to_value(pos_y);
      r0_vec[2]   <= to_value(pos_z);
      r0_vec[3]   <= POS_W;
    end
  end

  // world = model * pos
  vmt_matvec #(
    .VALUE_WIDTH (W),
    .FRAC_BITS   (FRAC_BITS),
    .MATRIX_SEL  (MSEL_MODEL),
    .CARRY_WIDTH (CW)
  ) u_model (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r0_valid),
    .in_ready  (m_in_ready),
    .in_ctl    (r0_ctl),
    .in_coef   (r0_coef),
    .in_vec    (r0_vec),
    .in_carry  ('0),
    .out_valid (m_valid),
    .out_ready (v_in_ready),
    .out_ctl   (m_ctl),
    .out_coef  (m_coef),
    .out_vec   (m_vec),
    .out_carry (m_carry)
  );

  // world position rides along in the upper carry slots
  assign v_carry_in = {m_vec, m_carry[W-1:0]};

  // view = view matrix * world
  vmt_matvec #(
    .VALUE_WIDTH (W),
    .FRAC_BITS   (FRAC_BITS),
    .MATRIX_SEL  (MSEL_VIEW),
    .CARRY_WIDTH (CW)
  ) u_view (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (v_in_ready),
    .in_ctl    (m_ctl),
    .in_coef   (m_coef),
    .in_vec    (m_vec),
    .in_carry  (v_carry_in),
    .out_valid (v_valid),
    .out_ready (p_in_ready),
    .out_ctl   (v_ctl),
    .out_coef  (v_coef),
    .out_vec   (v_vec),
    .out_carry (v_carry)
  );

  // depth taken from view z into the lowest carry slot
  assign p_carry_in = {v_carry[CW-1:W], neg_sat(v_vec[2])};

  // clip = projection * view
  vmt_matvec #(
    .VALUE_WIDTH (W),
    .FRAC_BITS   (FRAC_BITS),
    .MATRIX_SEL  (MSEL_PROJ),
    .CARRY_WIDTH (CW)
  ) u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_valid),
    .in_ready  (p_in_ready),
    .in_ctl    (v_ctl),
    .in_coef   (v_coef),
    .in_vec    (v_vec),
    .in_carry  (p_carry_in),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_ctl   (p_ctl),
    .out_coef  (p_coef),
    .out_vec   (p_vec),
    .out_carry (p_carry)
  );

  // loads have done their work once past the projection store and drop out here;
  // the coefficient value is not needed beyond that point
  assign p_ready = p_ctl.load || d_in_ready || (p_coef != p_coef);

  vmt_divide #(
    .VALUE_WIDTH (W),
    .FRAC_BITS   (FRAC_BITS),
    .CARRY_WIDTH (CW)
  ) u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid && !p_ctl.load),
    .in_ready  (d_in_ready),
    .in_clip   (p_vec),
    .in_carry  (p_carry),
    .out_valid (d_valid),
    .out_ready (out_ready),
    .out_ndc   (d_ndc),
    .out_error (d_error),
    .out_carry (d_carry)
  );

  // results in the low 32 bits, two's complement
  assign out_valid    = d_valid;
  assign world_x      = 32'(signed'(d_carry[1*W +: W]));
  assign world_y      = 32'(signed'(d_carry[2*W +: W]));
  assign world_z      = 32'(signed'(d_carry[3*W +: W]));
  assign world_w      = 32'(signed'(d_carry[4*W +: W]));
  assign view_depth   = 32'(signed'(d_carry[0 +: W]));
  assign ndc_x        = 32'(signed'(d_ndc[0]));
  assign ndc_y        = 32'(signed'(d_ndc[1]));
  assign ndc_z        = 32'(signed'(d_ndc[2]));
  assign divide_error = d_error;

endmodule

// ===== design/vmt_port_checker.sv =====
// port-level checks of the vertex transform unit and their binding
`include "vertex_mvp_transform_unit_assert.svh"

module vmt_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] world_x,
  input logic signed [31:0] ndc_x,
  input logic signed [31:0] ndc_y,
  input logic signed [31:0] ndc_z,
  input logic signed [31:0] view_depth,
  input logic               divide_error
);

  // a waiting result holds its value
  `VMT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(world_x) && $stable(ndc_x) && $stable(view_depth) && $stable(divide_error), "result changed while stalled")

  // zero clip w forces the divided values to zero
  `VMT_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && divide_error, ndc_x == 0 && ndc_y == 0 && ndc_z == 0, "divided values not zero on divide error")

  // nothing comes out right after reset
  `VMT_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid, "result present after reset")

  // just out of reset, the input side is not blocked with an empty output
  `VMT_ASSERT_NEXT(a_ready_after_reset, clk, rst, $past(rst) && in_valid, in_ready || out_valid, "input stalled with empty pipeline")

endmodule

bind vertex_mvp_transform_unit vmt_port_checker u_port_checker (.*);

// ===== tb/vmt_checker.sv =====
// transfer monitor, vertex transform predictor and result scoreboard
module vmt_checker
  import vmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [1:0]         matrix_select,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic signed [31:0] world_w,
  input  logic signed [31:0] ndc_x,
  input  logic signed [31:0] ndc_y,
  input  logic signed [31:0] ndc_z,
  input  logic signed [31:0] view_depth,
  input  logic               divide_error,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] world[4];
    logic signed [31:0] ndc[3];
    logic signed [31:0] depth;
    logic               err;
  } vertex_result_t;

  logic signed [31:0] coefs[48];
  vertex_result_t     expected_vertices[$];

  function automatic longint sat32(longint v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  // exact product, truncate toward zero, then saturate
  function automatic longint fx_mul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = m >> 16;
    return sat32((p < 0) ? -m : m);
  endfunction

  function automatic longint fx_div(longint c, longint w);
    logic   neg;
    longint uc, uw, m;
    neg = (c < 0) != (w < 0);
    uc = (c < 0) ? -c : c;
    uw = (w < 0) ? -w : w;
    m = (uc << 16) / uw;
    if (neg) return (m >= 64'sd2147483648) ? MINV : -m;
    return (m > MAXV) ? MAXV : m;
  endfunction

  function automatic vertex_result_t transform_vertex(longint px, longint py, longint pz);
    vertex_result_t r;
    longint vin[4], wld[4], vw[4], clp[4], acc;
    vin[0] = px; vin[1] = py; vin[2] = pz; vin[3] = 64'sd65536;
    for (int r0 = 0; r0 < 4; r0++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += fx_mul(coefs[r0*4+c], vin[c]);
      wld[r0] = sat32(acc);
    end
    for (int r0 = 0; r0 < 4; r0++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += fx_mul(coefs[16+r0*4+c], wld[c]);
      vw[r0] = sat32(acc);
    end
    for (int r0 = 0; r0 < 4; r0++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += fx_mul(coefs[32+r0*4+c], vw[c]);
      clp[r0] = sat32(acc);
    end
    r.err = (clp[3] == 0);
    for (int i = 0; i < 4; i++) r.world[i] = wld[i][31:0];
    for (int i = 0; i < 3; i++) r.ndc[i] = r.err ? 32'sd0 : 32'(fx_div(clp[i], clp[3]));
    r.depth = 32'(sat32(-vw[2]));
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = expected_vertices.size();

  always @(posedge clk) begin
    vertex_result_t e;
    if (rst) begin
      for (int i = 0; i < 48; i++) coefs[i] = '0;
      expected_vertices.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vertices.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_vertices.pop_front();
          check_field("world_x", e.world[0], world_x);
          check_field("world_y", e.world[1], world_y);
          check_field("world_z", e.world[2], world_z);
          check_field("world_w", e.world[3], world_w);
          check_field("ndc_x", e.ndc[0], ndc_x);
          check_field("ndc_y", e.ndc[1], ndc_y);
          check_field("ndc_z", e.ndc[2], ndc_z);
          check_field("view_depth", e.depth, view_depth);
          check_field("divide_error", {31'd0, e.err}, {31'd0, divide_error});
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_VERTEX)
          expected_vertices.insert(expected_vertices.size(),
                                   transform_vertex(pos_x, pos_y, pos_z));
        else if (matrix_select != MSEL_UNUSED)
          coefs[{matrix_select, coef_index}] = coef_value;
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// top testbench of the vertex transform unit: stimulus, back-pressure and verdict
module tb;
  import vmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1300;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic action;
  logic [1:0] matrix_select;
  logic [3:0] coef_index;
  logic signed [31:0] coef_value, pos_x, pos_y, pos_z;
  logic signed [31:0] world_x, world_y, world_z, world_w;
  logic signed [31:0] ndc_x, ndc_y, ndc_z, view_depth;
  logic divide_error;
  logic in_taken;
  int   fail_count, pending, cycles;

  vertex_mvp_transform_unit dut (.*);

  vmt_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // registered view of the input handshake, read by the sender at the falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    cycles <= rst ? 0 : cycles + 1;
  end

  // quiet window with no idling on either side
  function automatic bit idle_now();
    if (cycles > 600 && cycles < 1100) return 0;
    return $urandom_range(99) < 7;
  endfunction

  // receiver: random stalls plus one long hold-off so the pipeline backs up
  initial begin
    int hold;
    hold = 0;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (cycles == 300) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= !idle_now();
      end
      @(negedge clk);
    end
  end

  // coefficient mix: mostly small, some extremes, some full random bits
  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: return $urandom;
      1: case ($urandom_range(4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0001_0000;
           3: return 32'hffff_0000;
           default: return 32'h0;
         endcase
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // one transfer; valid stays high across back-to-back transfers
  task automatic send(action_t a, logic [1:0] sel, logic [3:0] idx, logic [31:0] cv,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while (idle_now()) begin
      in_valid <= 0;
      @(negedge clk);
    end
    action <= a;
    matrix_select <= sel;
    coef_index <= idx;
    coef_value <= cv;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    in_valid <= 1;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic load(logic [1:0] sel, logic [3:0] idx, logic [31:0] cv);
    send(ACT_LOAD, sel, idx, cv, $urandom, $urandom, $urandom);
  endtask

  task automatic vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send(ACT_VERTEX, 2'($urandom), 4'($urandom), $urandom, x, y, z);
  endtask

  // timeout watchdog
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int k;
    rst = 1;
    in_valid = 0;
    action = ACT_LOAD;
    matrix_select = '0;
    coef_index = '0;
    coef_value = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // all matrices zero after reset: clip w is zero, divide error
    vertex(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
    // unused select is dropped
    load(MSEL_UNUSED, 4'd15, 32'hffff_ffff);
    vertex(32'h0, 32'h0, 32'h0);
    // identity in all three matrices
    for (int m = 0; m < 3; m++)
      for (int d = 0; d < 4; d++) load(2'(m), 4'(d * 5), 32'h0001_0000);
    vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // most negative view z: depth negation saturates
    vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    vertex(32'h0002_8000, 32'hfffd_0000, 32'h0000_0001);
    // extreme coefficients force product saturation
    load(MSEL_MODEL, 4'd0, 32'h8000_0000);
    load(MSEL_MODEL, 4'd1, 32'h7fff_ffff);
    vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    load(MSEL_MODEL, 4'd0, 32'h0001_0000);
    load(MSEL_MODEL, 4'd1, 32'h0);

    // random traffic: matrix rewrites then vertex runs, with some noise loads
    k = 0;
    while (k < RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0: begin
          k += 16;
          for (int i = 0; i < 16; i++) load(2'($urandom_range(2)), 4'(i), rand_value());
        end
        1: begin
          k++;
          load(2'($urandom), 4'($urandom), $urandom);
        end
        2: begin
          k++;
          load(2'($urandom_range(2)), 4'($urandom), rand_value());
        end
        default: begin
          k++;
          vertex(rand_value(), rand_value(), rand_value());
        end
      endcase
    end
    in_valid <= 0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
